// ===== sv/sre_pkg.sv =====
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types, register codes and constants of the moving average and
// strength index engine.
// ----------------------------------------------------------------------------
package sre_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int PRICE_BITS_DEF = 32;

	localparam int PRICE_W     = 32;
	localparam int LEN_REG_W   = 7;
	localparam int LEVEL_W     = 15;
	localparam int FRAC_EXTRA  = 16;
	localparam int CFG_ADDR_W  = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int REG_IDX_W   = 2;

	localparam logic [LEN_REG_W-1:0] WINDOW_RESET = 7'd14;
	localparam logic [LEVEL_W-1:0]   BUY_RESET    = 15'd7680;
	localparam logic [LEVEL_W-1:0]   SELL_RESET   = 15'd17920;
	localparam logic [LEVEL_W-1:0]   RSI_FULL     = 15'd25600;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BUY    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SELL   = 2'd2;

	localparam logic [1:0] MOM_NONE   = 2'd0;
	localparam logic [1:0] MOM_BUY    = 2'd1;
	localparam logic [1:0] MOM_SELL   = 2'd2;
	localparam logic [1:0] TREND_NONE = 2'd0;
	localparam logic [1:0] TREND_UP   = 2'd1;
	localparam logic [1:0] TREND_DOWN = 2'd2;

	typedef struct packed {
		logic [PRICE_W-1:0] close_price;
		logic               series_start;
	} sample_t;

	typedef struct packed {
		logic [PRICE_W-1:0] average_value;
		logic               average_valid;
		logic [LEVEL_W-1:0] strength_index;
		logic               strength_valid;
		logic [1:0]         momentum_signal;
		logic [1:0]         trend_signal;
	} result_t;

	typedef struct packed {
		logic [LEN_REG_W-1:0] window_length;
		logic [LEVEL_W-1:0]   rsi_buy_level;
		logic [LEVEL_W-1:0]   rsi_sell_level;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_AVG_PREP,
		S_AVG_RUN,
		S_ACC,
		S_GAIN_PREP,
		S_GAIN_RUN,
		S_LOSS_PREP,
		S_LOSS_RUN,
		S_RSI_PREP,
		S_RSI_RUN,
		S_DONE
	} state_t;

endpackage

// ===== sv/sre_ram.sv =====
// ----------------------------------------------------------------------------
// sre_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/sre_divider.sv =====
// ----------------------------------------------------------------------------
// sre_divider
// Shared restoring divider, one quotient bit per cycle. The dividend comes
// in left aligned so that the given step count yields the full quotient.
// ----------------------------------------------------------------------------
module sre_divider #(
	parameter int DVD_W = 63,
	parameter int DSR_W = 49,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	input  logic [CNT_W-1:0] steps,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVD_W-1:0] dq_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;
	logic [DSR_W-1:0] rem_d;

	always_comb begin
		trial = {rem_q, dq_q[DVD_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
		rem_d = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], fits};
			rem_q <= rem_d;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ===== sv/sre_regs.sv =====
// ----------------------------------------------------------------------------
// sre_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module sre_regs
	import sre_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg,
	output logic                  length_wr
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign idx       = paddr[CFG_ADDR_W-1:2];
	assign wr_en     = psel && penable && pwrite;
	assign length_wr = wr_en && (idx == REG_WINDOW);
	assign pready    = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length  <= WINDOW_RESET;
			cfg_q.rsi_buy_level  <= BUY_RESET;
			cfg_q.rsi_sell_level <= SELL_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_WINDOW: cfg_q.window_length  <= pwdata[LEN_REG_W-1:0];
				REG_BUY:    cfg_q.rsi_buy_level  <= pwdata[LEVEL_W-1:0];
				REG_SELL:   cfg_q.rsi_sell_level <= pwdata[LEVEL_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WINDOW: prdata = CFG_DATA_W'(cfg_q.window_length);
			REG_BUY:    prdata = CFG_DATA_W'(cfg_q.rsi_buy_level);
			REG_SELL:   prdata = CFG_DATA_W'(cfg_q.rsi_sell_level);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== sv/sma_rsi_signal_engine.sv =====
// ----------------------------------------------------------------------------
// sma_rsi_signal_engine
// Simple moving average and Wilder strength index over a price series, with
// buy/sell flags from index levels and up/down flags from price vs average.
//
//   channel  | direction | handshake                   | word
//   sample   | in        | sample_valid / sample_ready | sample_t
//   result   | out       | result_valid / result_ready | result_t
//   config   | in        | psel / penable / pwrite     | 32-bit register
//
// one sample at a time through a sequencer around one shared divider,
// one quotient bit per cycle; up to four divisions per sample: the
// average, then once the index runs the smoothed gain and loss, and the
// index itself unless the average loss is zero
// no clearing pass after reset: the price window is only used once written
// a finished word waits in the result register; the next sample is taken
// while it waits
// ----------------------------------------------------------------------------
module sma_rsi_signal_engine
	import sre_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int PB        = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
	localparam int LEN_TOP   = (1 << LEN_REG_W) - 1;
	localparam int LEN_MAX   = (WINDOW_MAX < LEN_TOP) ? WINDOW_MAX : LEN_TOP;
	localparam int LEN_BITS  = $clog2(LEN_MAX + 1);
	localparam int SEEN_BITS = $clog2(LEN_MAX + 2);
	localparam int SLOT_BITS = $clog2(WINDOW_MAX);
	localparam int CMP_A     = (SLOT_BITS > LEN_BITS) ? SLOT_BITS : LEN_BITS;
	localparam int CMP_W     = ((CMP_A > SEEN_BITS) ? CMP_A : SEEN_BITS) + 1;
	localparam int SUM_BITS  = PB + LEN_BITS;
	localparam int GL_BITS   = PB + FRAC_EXTRA;
	localparam int NUM_BITS  = GL_BITS + LEN_BITS;
	localparam int RSI_BITS  = GL_BITS + LEVEL_W;
	localparam int DVD_A     = (NUM_BITS > RSI_BITS) ? NUM_BITS : RSI_BITS;
	localparam int DVD_W     = (DVD_A > SUM_BITS) ? DVD_A : SUM_BITS;
	localparam int DSR_W     = GL_BITS + 1;
	localparam int CNT_W     = $clog2(DVD_W + 1);
	localparam int SUM_SH    = DVD_W - SUM_BITS;
	localparam int NUM_SH    = DVD_W - NUM_BITS;
	localparam int RSI_SH    = DVD_W - RSI_BITS;

	cfg_t                  cfg;
	logic                  length_wr;
	state_t                state_q;
	state_t                state_d;

	logic [LEN_BITS-1:0]   len;
	logic [LEN_BITS-1:0]   lenm1;
	logic                  accept;
	logic                  ram_we;
	logic [PB-1:0]         ram_rdata;
	logic [SLOT_BITS-1:0]  slot_eff;
	logic [SLOT_BITS-1:0]  slot_next;
	logic                  avg_ok;
	logic                  rsi_ok;
	logic                  warm;
	logic                  at_len;
	logic                  loss_nz;
	logic                  load_result;
	logic [NUM_BITS-1:0]   gain_numer;
	logic [NUM_BITS-1:0]   loss_numer;
	logic [RSI_BITS-1:0]   rsi_prod;
	result_t               result_d;

	logic                  div_start;
	logic                  div_busy;
	logic                  div_done;
	logic [DVD_W-1:0]      div_quo;
	logic [DVD_W-1:0]      div_dvd_q;
	logic [DSR_W-1:0]      div_dsr_q;
	logic [CNT_W-1:0]      div_steps_q;

	logic [SLOT_BITS-1:0]  slot_q;
	logic [SEEN_BITS-1:0]  seen_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [PB-1:0]         prev_q;
	logic [GL_BITS-1:0]    gain_q;
	logic [GL_BITS-1:0]    loss_q;
	logic [PB-1:0]         price_q;
	logic [PB-1:0]         up_q;
	logic [PB-1:0]         down_q;
	logic [SUM_BITS-1:0]   scaled_q;
	logic [1:0]            trend_q;
	logic [PB-1:0]         avg_q;
	logic [LEVEL_W-1:0]    rsi_q;
	logic                  result_valid_q;
	result_t               result_q;

	sre_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.length_wr (length_wr)
	);

	sre_ram #(
		.WIDTH (PB),
		.DEPTH (WINDOW_MAX)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (price_q),
		.re    (accept),
		.raddr (slot_eff),
		.rdata (ram_rdata)
	);

	sre_divider #(
		.DVD_W (DVD_W),
		.DSR_W (DSR_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd_q),
		.divisor  (div_dsr_q),
		.steps    (div_steps_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// effective window length
	always_comb begin
		if (cfg.window_length == '0) begin
			len = LEN_BITS'(1);
		end else if (32'(cfg.window_length) > 32'(LEN_MAX)) begin
			len = LEN_BITS'(LEN_MAX);
		end else begin
			len = cfg.window_length[LEN_BITS-1:0];
		end
		lenm1 = len - LEN_BITS'(1);
	end

	always_comb begin
		avg_ok  = (CMP_W'(seen_q) + CMP_W'(1)) >= CMP_W'(len);
		rsi_ok  = CMP_W'(seen_q) >= CMP_W'(len);
		at_len  = CMP_W'(seen_q) == CMP_W'(len);
		warm    = (seen_q != '0) && !rsi_ok;
		loss_nz = loss_q != '0;

		if (sample.series_start || (CMP_W'(slot_q) >= CMP_W'(len))) begin
			slot_eff = '0;
		end else begin
			slot_eff = slot_q;
		end
		if ((CMP_W'(slot_q) + CMP_W'(1)) >= CMP_W'(len)) begin
			slot_next = '0;
		end else begin
			slot_next = slot_q + SLOT_BITS'(1);
		end

		if (at_len) begin
			gain_numer = (NUM_BITS'(gain_q) + NUM_BITS'(up_q)) << FRAC_EXTRA;
			loss_numer = (NUM_BITS'(loss_q) + NUM_BITS'(down_q)) << FRAC_EXTRA;
		end else begin
			gain_numer = NUM_BITS'(gain_q) * NUM_BITS'(lenm1)
				+ (NUM_BITS'(up_q) << FRAC_EXTRA);
			loss_numer = NUM_BITS'(loss_q) * NUM_BITS'(lenm1)
				+ (NUM_BITS'(down_q) << FRAC_EXTRA);
		end
		rsi_prod = RSI_BITS'(gain_q) * RSI_BITS'(RSI_FULL);
	end

	always_comb begin
		result_d.average_value   = avg_ok ? PRICE_W'(avg_q) : '0;
		result_d.average_valid   = avg_ok;
		result_d.strength_index  = rsi_q;
		result_d.strength_valid  = rsi_ok;
		result_d.trend_signal    = avg_ok ? trend_q : TREND_NONE;
		result_d.momentum_signal = MOM_NONE;
		if (rsi_ok) begin
			if (rsi_q < cfg.rsi_buy_level) begin
				result_d.momentum_signal = MOM_BUY;
			end else if (rsi_q > cfg.rsi_sell_level) begin
				result_d.momentum_signal = MOM_SELL;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (sample_valid) state_d = S_SUM;
			S_SUM:       state_d = S_AVG_PREP;
			S_AVG_PREP:  state_d = S_AVG_RUN;
			S_AVG_RUN:   if (div_done) state_d = S_ACC;
			S_ACC:       state_d = rsi_ok ? S_GAIN_PREP : S_RSI_PREP;
			S_GAIN_PREP: state_d = S_GAIN_RUN;
			S_GAIN_RUN:  if (div_done) state_d = S_LOSS_PREP;
			S_LOSS_PREP: state_d = S_LOSS_RUN;
			S_LOSS_RUN:  if (div_done) state_d = S_RSI_PREP;
			S_RSI_PREP:  state_d = (rsi_ok && loss_nz) ? S_RSI_RUN : S_DONE;
			S_RSI_RUN:   if (div_done) state_d = S_DONE;
			S_DONE:      if (!result_valid_q || result_ready) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready = 1'b0;
		ram_we       = 1'b0;
		div_start    = 1'b0;
		load_result  = 1'b0;
		case (state_q)
			S_IDLE:     sample_ready = 1'b1;
			S_SUM:      ram_we = 1'b1;
			S_AVG_RUN,
			S_GAIN_RUN,
			S_LOSS_RUN,
			S_RSI_RUN:  div_start = !div_busy && !div_done;
			S_DONE:     load_result = !result_valid_q || result_ready;
			default:    ;
		endcase
	end

	assign accept = sample_valid && sample_ready;

	// sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			slot_q         <= '0;
			seen_q         <= '0;
			sum_q          <= '0;
			prev_q         <= '0;
			gain_q         <= '0;
			loss_q         <= '0;
		end else begin
			state_q <= state_d;
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			if (length_wr) begin
				slot_q <= '0;
				seen_q <= '0;
				sum_q  <= '0;
				prev_q <= '0;
				gain_q <= '0;
				loss_q <= '0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (accept) begin
							slot_q <= slot_eff;
							if (sample.series_start) begin
								seen_q <= '0;
								sum_q  <= '0;
								prev_q <= '0;
								gain_q <= '0;
								loss_q <= '0;
							end
						end
					end
					S_SUM: begin
						sum_q  <= sum_q - (rsi_ok ? SUM_BITS'(ram_rdata) : '0)
							+ SUM_BITS'(price_q);
						slot_q <= slot_next;
					end
					S_ACC: begin
						if (warm) begin
							gain_q <= gain_q + GL_BITS'(up_q);
							loss_q <= loss_q + GL_BITS'(down_q);
						end
					end
					S_GAIN_RUN: if (div_done) gain_q <= GL_BITS'(div_quo);
					S_LOSS_RUN: if (div_done) loss_q <= GL_BITS'(div_quo);
					S_DONE: begin
						if (load_result) begin
							prev_q <= price_q;
							if (CMP_W'(seen_q) < (CMP_W'(len) + CMP_W'(1))) begin
								seen_q <= seen_q + SEEN_BITS'(1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) price_q <= sample.close_price[PB-1:0];
			S_SUM: begin
				up_q     <= (price_q > prev_q) ? price_q - prev_q : '0;
				down_q   <= (price_q < prev_q) ? prev_q - price_q : '0;
				scaled_q <= SUM_BITS'(price_q) * SUM_BITS'(len);
			end
			S_AVG_PREP: begin
				if (scaled_q > sum_q) begin
					trend_q <= TREND_UP;
				end else if (scaled_q < sum_q) begin
					trend_q <= TREND_DOWN;
				end else begin
					trend_q <= TREND_NONE;
				end
				div_dvd_q   <= DVD_W'(sum_q) << SUM_SH;
				div_dsr_q   <= DSR_W'(len);
				div_steps_q <= CNT_W'(SUM_BITS);
			end
			S_AVG_RUN: if (div_done) avg_q <= PB'(div_quo);
			S_GAIN_PREP: begin
				div_dvd_q   <= DVD_W'(gain_numer) << NUM_SH;
				div_dsr_q   <= DSR_W'(len);
				div_steps_q <= CNT_W'(NUM_BITS);
			end
			S_LOSS_PREP: begin
				div_dvd_q   <= DVD_W'(loss_numer) << NUM_SH;
				div_dsr_q   <= DSR_W'(len);
				div_steps_q <= CNT_W'(NUM_BITS);
			end
			S_RSI_PREP: begin
				rsi_q       <= rsi_ok ? RSI_FULL : '0;
				div_dvd_q   <= DVD_W'(rsi_prod) << RSI_SH;
				div_dsr_q   <= DSR_W'(gain_q) + DSR_W'(loss_q);
				div_steps_q <= CNT_W'(RSI_BITS);
			end
			S_RSI_RUN: if (div_done) rsi_q <= LEVEL_W'(div_quo);
			S_DONE: if (load_result) result_q <= result_d;
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> !div_busy)
		else $error("divider busy while sampling is open");

	a_strength_after_average: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.strength_valid || result.average_valid))
		else $error("strength index valid before average");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.strength_index <= RSI_FULL))
		else $error("strength index out of range");

	a_warmup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.average_valid) |->
			(result.average_value == '0 && result.trend_signal == TREND_NONE))
		else $error("average reported during warm-up");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives closing prices into the moving average and strength index engine
// over valid/ready with random gaps on both sides, and programs the window
// and index levels over the register port between phases. A predictor
// tracks the price window, running sum and smoothed gain/loss, and every
// result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import sre_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned stall_count = 0;
	bit          no_stall = 1'b0;
	result_t     pending_results[$];
	result_t     oldest_result;

	// predictor state and configuration
	logic [PRICE_W-1:0]   hist_prices [WINDOW_MAX_DEF];
	int unsigned          slot;
	int unsigned          seen_count;
	logic [63:0]          run_sum;
	logic [63:0]          last_close;
	logic [63:0]          gain_avg;
	logic [63:0]          loss_avg;
	logic [LEN_REG_W-1:0] cfg_window = WINDOW_RESET;
	logic [LEVEL_W-1:0]   cfg_buy = BUY_RESET;
	logic [LEVEL_W-1:0]   cfg_sell = SELL_RESET;

	sma_rsi_signal_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_stall || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void clear_series();
		slot = 0;
		seen_count = 0;
		run_sum = '0;
		last_close = '0;
		gain_avg = '0;
		loss_avg = '0;
	endfunction

	function automatic int unsigned active_length();
		if (cfg_window == '0)
			return 1;
		if (cfg_window > WINDOW_MAX_DEF)
			return WINDOW_MAX_DEF;
		return 32'(cfg_window);
	endfunction

	function automatic result_t predict_indicators(input logic [PRICE_W-1:0] price,
			input logic start);
		result_t     r;
		int unsigned len;
		int unsigned seen;
		logic [63:0] up;
		logic [63:0] down;
		logic [63:0] scaled;
		logic [63:0] rsi;
		r = '0;
		len = active_length();
		if (start)
			clear_series();
		seen = seen_count;

		// moving average
		if (slot >= len)
			slot = 0;
		if (seen >= len)
			run_sum = run_sum - 64'(hist_prices[slot]);
		hist_prices[slot] = price;
		slot = (slot + 1 >= len) ? 0 : slot + 1;
		run_sum = run_sum + 64'(price);
		if (seen + 1 >= len) begin
			r.average_valid = 1'b1;
			scaled = 64'(price) * 64'(len);
			r.average_value = 32'(run_sum / 64'(len));
			if (scaled > run_sum)
				r.trend_signal = TREND_UP;
			else if (scaled < run_sum)
				r.trend_signal = TREND_DOWN;
		end

		// wilder smoothing, plain sums during warm-up
		if (seen >= 1) begin
			up = (64'(price) > last_close) ? 64'(price) - last_close : 64'd0;
			down = (64'(price) < last_close) ? last_close - 64'(price) : 64'd0;
			if (seen <= len) begin
				gain_avg = gain_avg + up;
				loss_avg = loss_avg + down;
				if (seen == len) begin
					gain_avg = (gain_avg << FRAC_EXTRA) / 64'(len);
					loss_avg = (loss_avg << FRAC_EXTRA) / 64'(len);
				end
			end else begin
				gain_avg = (gain_avg * 64'(len - 1) + (up << FRAC_EXTRA)) / 64'(len);
				loss_avg = (loss_avg * 64'(len - 1) + (down << FRAC_EXTRA)) / 64'(len);
			end
		end
		if (seen >= len) begin
			r.strength_valid = 1'b1;
			if (loss_avg == '0)
				rsi = 64'(RSI_FULL);
			else
				rsi = (gain_avg * 64'(RSI_FULL)) / (gain_avg + loss_avg);
			r.strength_index = rsi[LEVEL_W-1:0];
			if (rsi < 64'(cfg_buy))
				r.momentum_signal = MOM_BUY;
			else if (rsi > 64'(cfg_sell))
				r.momentum_signal = MOM_SELL;
		end

		if (seen < len + 1)
			seen_count = seen + 1;
		last_close = 64'(price);
		return r;
	endfunction

	function automatic logic [PRICE_W-1:0] next_price(input logic [PRICE_W-1:0] p);
		longint      walk;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		case (pick)
			0: return $urandom;
			1: return '0;
			2: return '1;
			3: return p;
			default: begin
				walk = longint'(p) + longint'($urandom_range(0, 262143)) - 131072;
				if (walk < 0)
					walk = 0;
				if (walk > 64'hFFFF_FFFF)
					walk = 64'hFFFF_FFFF;
				return walk[PRICE_W-1:0];
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
			want);
		error_count++;
	endtask

	task automatic send_sample(input logic [PRICE_W-1:0] price, input logic start);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{close_price: price, series_start: start};
		do @(posedge clk); while (!sample_ready);
		pending_results.insert(pending_results.size(), predict_indicators(price, start));
	endtask

	task automatic wait_for_drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WINDOW: begin
				cfg_window = value[LEN_REG_W-1:0];
				clear_series();
			end
			REG_BUY: cfg_buy = value[LEVEL_W-1:0];
			REG_SELL: cfg_sell = value[LEVEL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// result side stalls
	always @(posedge clk) begin
		if (stall_count > 0) begin
			stall_count <= stall_count - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			stall_count <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing pending", 64'(result), 64'd0);
			end else begin
				oldest_result = pending_results.pop_front();
				if (result.average_value !== oldest_result.average_value)
					report_mismatch("average_value", 64'(result.average_value),
						64'(oldest_result.average_value));
				if (result.average_valid !== oldest_result.average_valid)
					report_mismatch("average_valid", 64'(result.average_valid),
						64'(oldest_result.average_valid));
				if (result.strength_index !== oldest_result.strength_index)
					report_mismatch("strength_index", 64'(result.strength_index),
						64'(oldest_result.strength_index));
				if (result.strength_valid !== oldest_result.strength_valid)
					report_mismatch("strength_valid", 64'(result.strength_valid),
						64'(oldest_result.strength_valid));
				if (result.momentum_signal !== oldest_result.momentum_signal)
					report_mismatch("momentum_signal", 64'(result.momentum_signal),
						64'(oldest_result.momentum_signal));
				if (result.trend_signal !== oldest_result.trend_signal)
					report_mismatch("trend_signal", 64'(result.trend_signal),
						64'(oldest_result.trend_signal));
			end
		end
	end

	task automatic test_short_window();
		write_register(REG_WINDOW, 32'd3);
		send_sample(32'h0000_0000, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		// restart in the middle of a running series
		send_sample(32'h7FFF_FFFF, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
	endtask

	task automatic test_flat_series();
		wait_for_drain();
		write_register(REG_WINDOW, 32'd2);
		send_sample(32'h0005_0000, 1'b1);
		repeat (3) send_sample(32'h0005_0000, 1'b0);
	endtask

	task automatic test_window_extremes();
		wait_for_drain();
		// zero length acts as one
		write_register(REG_WINDOW, 32'd0);
		send_sample(32'h0001_0000, 1'b1);
		send_sample(32'h0002_0000, 1'b0);
		send_sample(32'h0001_8000, 1'b0);
		wait_for_drain();
		// address past the register list
		write_register(REG_SPARE, 32'd5);
		send_sample(32'h0003_0000, 1'b0);
		send_sample(32'h0000_4000, 1'b0);
	endtask

	task automatic test_level_extremes();
		wait_for_drain();
		write_register(REG_WINDOW, 32'd1);
		write_register(REG_BUY, 32'd25600);
		write_register(REG_SELL, 32'd0);
		send_sample(32'd100, 1'b1);
		send_sample(32'd200, 1'b0);
		send_sample(32'd150, 1'b0);
		send_sample(32'd50, 1'b0);
		wait_for_drain();
		write_register(REG_BUY, 32'd0);
		write_register(REG_SELL, 32'd25600);
		send_sample(32'd50, 1'b0);
		send_sample(32'd60, 1'b0);
	endtask

	task automatic test_random_series();
		int unsigned      win;
		int unsigned      count;
		int unsigned      buy_level;
		int unsigned      sell_level;
		bit               restart;
		logic [PRICE_W-1:0] price;
		for (int phase = 0; phase < 8; phase++) begin
			wait_for_drain();
			case (phase)
				0: begin
					// above the maximum, saturates to the full window
					win = 127;
					count = 100;
				end
				1: begin
					win = 1;
					count = 35;
				end
				2: begin
					win = 64;
					count = 40;
					no_stall = 1'b1;
				end
				default: begin
					win = $urandom_range(2, 16);
					count = $urandom_range(50, 60);
				end
			endcase
			case (phase % 3)
				1: begin
					buy_level = 0;
					sell_level = 25600;
				end
				2: begin
					buy_level = $urandom_range(0, 12800);
					sell_level = $urandom_range(12800, 25600);
				end
				default: begin
					buy_level = $urandom_range(0, 25600);
					sell_level = $urandom_range(0, 25600);
				end
			endcase
			write_register(REG_WINDOW, win);
			write_register(REG_BUY, buy_level);
			write_register(REG_SELL, sell_level);
			price = $urandom;
			for (int i = 0; i < count; i++) begin
				restart = (i == 0) || ($urandom_range(0, 99) < 3);
				price = restart ? $urandom : next_price(price);
				send_sample(price, restart);
				if ($urandom_range(0, 59) == 0 || (phase == 3 && i == count / 2))
					wait_for_drain();
			end
			no_stall = 1'b0;
		end
	endtask

	initial begin
		clear_series();
		for (int i = 0; i < WINDOW_MAX_DEF; i++)
			hist_prices[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_window();
		test_flat_series();
		test_window_extremes();
		test_level_extremes();
		test_random_series();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
